[src/bsm_pkg.sv]
// Shared types and constants for the bounded SplitMix64 random source.
package bsm_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned HALF_W   = WORD_W / 2;
    localparam int unsigned CNT_W    = 6;

    localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;

    localparam int unsigned SHIFT_PRE = 30;
    localparam int unsigned SHIFT_A   = 27;
    localparam int unsigned SHIFT_B   = 31;

    // Last count of the radix-2 remainder loop and of the partial-product loop.
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(2);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LIMIT_DIV,
        ST_DRAW,
        ST_MUL_A,
        ST_XS_A,
        ST_MUL_B,
        ST_XS_B,
        ST_CHECK,
        ST_VAL_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic {
        DIV_SRC_NEG_BOUND,
        DIV_SRC_MIXED
    } div_src_t;

    typedef enum logic {
        MIX_ROUND_A,
        MIX_ROUND_B
    } mix_round_t;

    typedef struct packed {
        logic             load_bound;
        logic             draw;
        logic             mul_en;
        logic [1:0]       mul_step;
        mix_round_t       round;
        logic             xs_en;
        logic             div_start;
        div_src_t         div_src;
        logic             div_step;
        logic             load_value;
        logic             value_zero;
    } dp_cmd_t;

    typedef struct packed {
        logic bound_small;
        logic draw_ok;
    } dp_stat_t;

endpackage

[src/bounded_splitmix64_random.sv]
// Top level of the bounded SplitMix64 random source.
//
// Each input beat on in_valid/in_ready carries a 64-bit bound; each output
// beat on out_valid/out_ready returns one value uniformly drawn from 0 to
// bound minus one. A bound of 0 or 1 returns 0 and leaves the generator alone.
// The block handles one request at a time: in_ready is high only while the
// controller is idle.
// For a bound of 2 or more, the rejection threshold (2^64 - bound) mod bound
// is found with a radix-2 remainder unit. Each draw then takes one counter
// add with the first xor-shift, two rounds of three partial products on one
// shared 32x32 multiplier, each followed by an xor-shift, and a threshold
// compare. Rejected draws repeat that loop. The accepted value then goes
// through the same remainder unit to give the result.
// The result waits in an output register, so a stalled receiver only holds
// the block once the next result is ready while the previous one is unread.
// Writing cfg_wdata with cfg_we loads the generator counter; reset sets the
// counter to 0 and empties the output register.
module bounded_splitmix64_random
    import bsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [WORD_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] bound,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller owns the handshakes and the step counter.
    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the counter, the mixer and the remainder unit.
    bsm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bound     (bound),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value)
    );

endmodule

[src/bsm_dp.sv]
// Datapath: generator counter, mixer with a shared 32x32 multiplier, radix-2 remainder unit.
module bsm_dp
    import bsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [WORD_W-1:0] cfg_wdata,
    input  logic [WORD_W-1:0] bound,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic [WORD_W-1:0] value
);

    logic [WORD_W-1:0] ctr_reg,   ctr_next;
    logic [WORD_W-1:0] bound_reg, bound_next;
    logic [WORD_W-1:0] z_reg,     z_next;
    logic [WORD_W-1:0] acc_reg,   acc_next;
    logic [WORD_W-1:0] rem_reg,   rem_next;
    logic [WORD_W-1:0] dvd_reg,   dvd_next;
    logic [WORD_W-1:0] value_reg, value_next;

    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] mul_k;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [WORD_W-1:0] prod;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_diff;

    assign sum   = ctr_reg + GOLDEN_INC;
    assign mul_k = (cmd.round == MIX_ROUND_A) ? MIX_MUL_A : MIX_MUL_B;

    // Low word of z*k from three partial products: lo*lo, hi*lo and lo*hi.
    assign op_a = (cmd.mul_step == 2'd1) ? z_reg[WORD_W-1:HALF_W] : z_reg[HALF_W-1:0];
    assign op_b = (cmd.mul_step == 2'd2) ? mul_k[WORD_W-1:HALF_W] : mul_k[HALF_W-1:0];
    assign prod = WORD_W'(op_a) * WORD_W'(op_b);

    assign rem_shift = {rem_reg, dvd_reg[WORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, bound_reg};

    assign stat.bound_small = (bound_reg[WORD_W-1:1] == '0);
    assign stat.draw_ok     = (z_reg >= rem_reg);
    assign value            = value_reg;

    always_comb
    begin
        ctr_next   = ctr_reg;
        bound_next = bound_reg;
        z_next     = z_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        value_next = value_reg;

        if (cfg_we)
        begin
            ctr_next = cfg_wdata;
        end
        if (cmd.load_bound)
        begin
            bound_next = bound;
        end
        if (cmd.draw)
        begin
            ctr_next = sum;
            z_next   = sum ^ (sum >> SHIFT_PRE);
        end
        if (cmd.mul_en)
        begin
            if (cmd.mul_step == 2'd0)
            begin
                acc_next = prod;
            end
            else
            begin
                acc_next = acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            end
        end
        if (cmd.xs_en)
        begin
            if (cmd.round == MIX_ROUND_A)
            begin
                z_next = acc_reg ^ (acc_reg >> SHIFT_A);
            end
            else
            begin
                z_next = acc_reg ^ (acc_reg >> SHIFT_B);
            end
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
            dvd_next = (cmd.div_src == DIV_SRC_NEG_BOUND) ? (WORD_W'(0) - bound_reg) : z_reg;
        end
        if (cmd.div_step)
        begin
            rem_next = rem_diff[WORD_W] ? rem_shift[WORD_W-1:0] : rem_diff[WORD_W-1:0];
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
        end
        if (cmd.load_value)
        begin
            value_next = cmd.value_zero ? '0 : rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
        end
        else
        begin
            ctr_reg <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
        z_reg     <= z_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        value_reg <= value_next;
    end

endmodule

[src/bsm_ctrl.sv]
// Controller: sequences the threshold division, draw loop, final division and output beat.
module bsm_ctrl
    import bsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             triv_reg,  triv_next;
    logic             ov_reg,    ov_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        triv_next  = triv_reg;
        ov_next    = ov_reg & ~out_ready;
        cmd        = '0;
        cmd.mul_step = cnt_reg[1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_bound = 1'b1;
                    state_next     = ST_START;
                end
            end
            ST_START:
            begin
                triv_next = stat.bound_small;
                cnt_next  = '0;
                if (stat.bound_small)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_SRC_NEG_BOUND;
                    state_next    = ST_LIMIT_DIV;
                end
            end
            ST_LIMIT_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                cmd.draw   = 1'b1;
                cnt_next   = '0;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.mul_en = 1'b1;
                cmd.round  = MIX_ROUND_A;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_XS_A;
                end
            end
            ST_XS_A:
            begin
                cmd.xs_en  = 1'b1;
                cmd.round  = MIX_ROUND_A;
                cnt_next   = '0;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_en = 1'b1;
                cmd.round  = MIX_ROUND_B;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_XS_B;
                end
            end
            ST_XS_B:
            begin
                cmd.xs_en  = 1'b1;
                cmd.round  = MIX_ROUND_B;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // The remainder register still holds the rejection threshold here.
                if (stat.draw_ok)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_SRC_MIXED;
                    cnt_next      = '0;
                    state_next    = ST_VAL_DIV;
                end
                else
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_VAL_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.load_value = 1'b1;
                    cmd.value_zero = triv_reg;
                    ov_next        = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            triv_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            triv_reg  <= triv_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

[test/bounded_splitmix64_random_tb.sv]
// Self-checking testbench for the bounded SplitMix64 random source.
module bounded_splitmix64_random_tb;
    import bsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [WORD_W-1:0] word_t;

    // One row of the directed stimulus. When has_known is set, the expected
    // value is typed in and replaces the predicted one.
    typedef struct packed {
        word_t bound;
        logic  has_known;
        word_t known;
    } row_t;

    localparam int    CLK_PERIOD    = 8;
    localparam int    RESET_CYCLES  = 5;
    localparam int    NUM_PHASES    = 4;
    localparam int    ITEMS_PER_PH  = 420;
    localparam int    HOLD_CYCLES   = 1500;
    localparam int    HOLD_AT_ITEM  = 60;
    localparam int    SETTLE_CYCLES = 8;
    localparam int    END_CYCLES    = 200;
    localparam int    IDLE_LIMIT    = 20000;
    localparam int    REPORT_LIMIT  = 10;

    // Generator constants, written out here on their own so that a wrong
    // constant in the design cannot hide behind a shared one.
    localparam word_t STEP_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam word_t MIX_K1     = 64'hbf58_476d_1ce4_e5b9;
    localparam word_t MIX_K2     = 64'h94d0_49bb_1331_11eb;

    // Sender gap and receiver stall odds, in percent, for each random phase.
    localparam int GAP_PCT   [NUM_PHASES] = '{0, 59, 0, 8};
    localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 59, 8};

    // Directed rows: trivial bounds, the extremes of the field, bounds just
    // above a half or three quarters of the range that force frequent redraws,
    // and alternating bit patterns.
    localparam int NUM_DIRECTED = 20;
    localparam row_t DIRECTED [NUM_DIRECTED] = '{
        '{64'd0,                  1'b1, 64'd0},
        '{64'd1,                  1'b1, 64'd0},
        '{64'd2,                  1'b0, 64'd0},
        '{64'd3,                  1'b0, 64'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
        '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'd0},
        '{64'h8000_0000_0000_0000, 1'b0, 64'd0},
        '{64'h8000_0000_0000_0001, 1'b0, 64'd0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
        '{64'h5555_5555_5555_5555, 1'b0, 64'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
        '{64'h0000_0001_0000_0000, 1'b0, 64'd0},
        '{64'h0000_0001_0000_0001, 1'b0, 64'd0},
        '{64'd1,                  1'b1, 64'd0},
        '{64'd0,                  1'b1, 64'd0},
        '{64'd10,                 1'b0, 64'd0},
        '{64'hC000_0000_0000_0001, 1'b0, 64'd0},
        '{64'h8000_0000_0000_0003, 1'b0, 64'd0},
        '{64'd6,                  1'b0, 64'd0},
        '{64'hFFFF_FFFF_0000_0000, 1'b0, 64'd0}
    };

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  cfg_we    = 1'b0;
    word_t cfg_wdata = '0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    word_t bound     = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    word_t value;

    // Side information that travels with the input beat being offered.
    logic  offer_has_known = 1'b0;
    word_t offer_known     = '0;

    // Predictor state: the generator counter as the block should hold it.
    word_t gen_ctr = '0;

    // Values the block still owes, oldest first.
    word_t draws_due [$];

    int send_gap_pct = 0;
    int stall_pct    = 0;
    logic hold_go    = 1'b0;

    int mismatches    = 0;
    int items_taken   = 0;
    int trivial_items = 0;
    int results_seen  = 0;
    int redraws       = 0;
    int seeds_loaded  = 0;
    int idle_cycles   = 0;

    bounded_splitmix64_random dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .bound     (bound),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance the counter by the golden-ratio step and mix the new count
    // with two xor-shift-multiply rounds and a closing xor-shift.
    function automatic word_t mix_next();
        word_t z;
        gen_ctr = gen_ctr + STEP_GAMMA;
        z = gen_ctr;
        z = (z ^ (z >> 30)) * MIX_K1;
        z = (z ^ (z >> 27)) * MIX_K2;
        return z ^ (z >> 31);
    endfunction

    // Predict the value for one request. Mixed values below the cut
    // (2^64 - lim) mod lim are thrown away so that the final reduction
    // modulo lim carries no bias; each throw costs one more counter step.
    function automatic word_t draw_bounded(input word_t lim);
        word_t cut;
        word_t z;
        if (lim <= 64'd1)
            return '0;
        cut = (~lim + 64'd1) % lim;
        z = mix_next();
        while (z < cut)
        begin
            redraws++;
            z = mix_next();
        end
        return z % lim;
    endfunction

    // Random bounds are spread over several shapes: trivial ones, tiny ones,
    // full-width ones, ones just above half the range where nearly half the
    // draws are rejected, powers of two with no rejection at all, and
    // values of random width.
    function automatic word_t pick_bound();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 8)
            return word_t'($urandom_range(1, 0));
        else if (kind < 30)
            return word_t'($urandom_range(16, 2));
        else if (kind < 50)
            return {$urandom, $urandom};
        else if (kind < 65)
            return 64'h8000_0000_0000_0000 + word_t'($urandom_range(1000, 1));
        else if (kind < 80)
            return word_t'(1) << $urandom_range(63, 1);
        else
            return {$urandom, $urandom} >> $urandom_range(63, 0);
    endfunction

    task automatic report_miss(input string what, input word_t want, input word_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Offer one beat on the input channel and return right after the edge
    // at which it is taken. Idle cycles are inserted ahead of it at random.
    // Called at a rising edge, so every input changes one step after it.
    task automatic offer(input word_t lim, input logic has_known, input word_t known);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        bound           <= lim;
        offer_has_known <= has_known;
        offer_known     <= known;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop sending and wait until every owed value has come back. At least
    // one edge passes first, so the beat taken at the last edge is counted.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (draws_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load the generator counter while the block is idle.
    task automatic load_seed(input word_t s);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we  <= 1'b0;
        gen_ctr = s;
        seeds_loaded++;
    endtask

    // Monitor. The expected value is worked out when the input beat is
    // taken, and every output beat is checked against the oldest one.
    always @(posedge clk)
    begin
        word_t want;
        if (in_valid && in_ready)
        begin
            want = draw_bounded(bound);
            if (offer_has_known)
                want = offer_known;
            draws_due = {draws_due, want};
            items_taken++;
            if (bound <= 64'd1)
                trivial_items++;
        end
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (draws_due.size() == 0)
                report_miss("result beat with nothing pending", '0, value);
            else
            begin
                want = draws_due.pop_front();
                if (value !== want)
                    report_miss("value mismatch", want, value);
            end
        end
    end

    // Receiver. It stalls at random, and on request it holds off once for a
    // long stretch so that the output register fills and the block has to
    // stall its input.
    always @(posedge clk)
    begin
        int hold_left;
        bit hold_used;
        if (hold_go && !hold_used)
        begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a long run of cycles with no beat on either channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        word_t seed_pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run from the reset counter of zero with no idling.
        for (int i = 0; i < NUM_DIRECTED; i++)
            offer(DIRECTED[i].bound, DIRECTED[i].has_known, DIRECTED[i].known);
        drain_results();

        // Random part. Each phase loads a new seed, the two extremes among
        // them, then runs with its own mix of sender gaps and receiver stalls.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
                seed_pick = '1;
            else if (p == 2)
                seed_pick = '0;
            else
                seed_pick = {$urandom, $urandom};
            load_seed(seed_pick);
            send_gap_pct = GAP_PCT[p];
            stall_pct    = STALL_PCT[p];
            for (int i = 0; i < ITEMS_PER_PH; i++)
            begin
                // In the first phase, free of sender gaps, the receiver goes quiet
                // once, while beats keep being offered.
                if (p == 0 && i == HOLD_AT_ITEM)
                    hold_go <= 1'b1;
                offer(pick_bound(), 1'b0, '0);
            end
            drain_results();
        end

        // Anything the block sends from here on has no expectation.
        stall_pct = 0;
        repeat (END_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d trivial bounds) across %0d seeds and four idling mixes.",
                 items_taken, trivial_items, seeds_loaded + 1);
        $display("Checked %0d results; %0d draws were rejected and redrawn; %0d mismatches.",
                 results_seen, redraws, mismatches);
        if (mismatches == 0 && draws_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
